@@ hdl/tlil_pkg.sv @@
// Package for the text line index lookup: sizes, character codes, item kinds and states.
package tlil_pkg;

  localparam int MAX_LINES = 1024;
  localparam int LINE_BITS = $clog2(MAX_LINES);
  localparam int POS_BITS  = 20;
  localparam int CHAR_BITS = 21;
  localparam int OFS_BITS  = 16;
  localparam int LNUM_BITS = 17;

  localparam logic [CHAR_BITS-1:0] CH_CR = CHAR_BITS'(13);
  localparam logic [CHAR_BITS-1:0] CH_LF = CHAR_BITS'(10);
  localparam logic [POS_BITS-1:0]  POS_MAX = {POS_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LAST_LINE = LINE_BITS'(MAX_LINES - 1);

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_QUERY = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CMP,
    ST_DONE
  } state_e;

  localparam logic REG_LINE_OFFSET = 1'b0;

endpackage

@@ hdl/text_line_index_lookup.sv @@
// Top level of the text line index lookup: line-start memory and binary search.
//
// Input channel (in_valid_i / in_stall_o) carries kind, char_code and query_pos.
// A script character or clear takes effect on its transfer and gives no
// result; characters stream at one per cycle while the input is not stalled,
// and line breaks write the line-start memory directly. A query
// binary-searches the line-start memory; each probe is a synchronous read,
// then a compare. With n lines recorded it needs at most ceil(log2(n)) probes
// before its result is loaded; the input stalls meanwhile.
// Output channel (out_valid_o / out_stall_i) carries line_number, column and
// overflow from an output register. While a result waits under stall, more
// characters may be taken; a following query searches and then holds in its
// last step until the output register is free.
// line_offset is written over the APB port at address 0 and is kept on clear.
// Reset clears counters, flags and the output valid flag; the memory is not
// cleared, only entries written since the last clear are ever read.
module text_line_index_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic [tlil_pkg::CHAR_BITS-1:0] char_code_i,
  input  logic [tlil_pkg::POS_BITS-1:0]  query_pos_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tlil_pkg::LNUM_BITS-1:0] line_number_o,
  output logic [tlil_pkg::POS_BITS-1:0]  column_o,
  output logic                          overflow_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tlil_pkg::*;

  logic [POS_BITS-1:0] mem [MAX_LINES];

  state_e state_q, state_d;
  logic [OFS_BITS-1:0]  offset_q;
  logic [POS_BITS-1:0]  next_pos_q, next_pos_d;
  logic [LINE_BITS-1:0] bc_q, bc_d;
  logic                 last_cr_q, last_cr_d;
  logic                 ovf_q, ovf_d;
  logic [POS_BITS-1:0]  pos_q, pos_d;
  logic [LINE_BITS:0]   s_q, s_d, e_q, e_d;
  logic [LINE_BITS-1:0] m_q, m_d;
  logic [POS_BITS-1:0]  sval_q, sval_d;
  logic [POS_BITS-1:0]  rd_data_q;
  logic                 out_valid_q, out_valid_d;
  logic [LNUM_BITS-1:0] lnum_q, lnum_d;
  logic [POS_BITS-1:0]  col_q, col_d;
  logic                 oovf_q, oovf_d;

  logic                 in_xfer, out_free, rd_en, wr_en;
  logic [LINE_BITS-1:0] wr_addr;
  logic [POS_BITS-1:0]  np_new;
  logic [LINE_BITS:0]   span, mid;
  kind_e                kind;

  assign kind       = kind_e'(kind_i);
  assign in_stall_o = state_q != ST_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign span       = e_q - s_q;
  assign mid        = s_q + (span >> 1);
  assign np_new     = (next_pos_q != POS_MAX) ? next_pos_q + POS_BITS'(1) : next_pos_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LINE_OFFSET) ? {16'd0, offset_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_LINE_OFFSET) begin
      offset_q <= pwdata[OFS_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && kind == KIND_QUERY) state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_d = (span > (LINE_BITS+1)'(1)) ? ST_CMP : ST_DONE;
      end
      ST_CMP: state_d = ST_SEARCH;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    next_pos_d  = next_pos_q;
    bc_d        = bc_q;
    last_cr_d   = last_cr_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    s_d         = s_q;
    e_d         = e_q;
    m_d         = m_q;
    sval_d      = sval_q;
    out_valid_d = out_valid_q && out_stall_i;
    lnum_d      = lnum_q;
    col_d       = col_q;
    oovf_d      = oovf_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = bc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (kind)
            KIND_CHAR: begin
              next_pos_d = np_new;
              if (next_pos_q == POS_MAX) ovf_d = 1'b1;
              if (char_code_i == CH_LF && last_cr_q) begin
                wr_en     = 1'b1;
                last_cr_d = 1'b0;
              end else if (char_code_i == CH_CR || char_code_i == CH_LF) begin
                if (bc_q == LAST_LINE) begin
                  ovf_d     = 1'b1;
                  last_cr_d = 1'b0;
                end else begin
                  bc_d      = bc_q + LINE_BITS'(1);
                  wr_addr   = bc_q + LINE_BITS'(1);
                  wr_en     = 1'b1;
                  last_cr_d = char_code_i == CH_CR;
                end
              end else begin
                last_cr_d = 1'b0;
              end
            end
            KIND_QUERY: begin
              pos_d  = query_pos_i;
              s_d    = '0;
              e_d    = {1'b0, bc_q} + (LINE_BITS+1)'(1);
              sval_d = '0;
            end
            KIND_CLEAR: begin
              next_pos_d = '0;
              bc_d       = '0;
              last_cr_d  = 1'b0;
              ovf_d      = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        if (span > (LINE_BITS+1)'(1)) begin
          m_d   = mid[LINE_BITS-1:0];
          rd_en = 1'b1;
        end
      end
      ST_CMP: begin
        if (rd_data_q > pos_q) begin
          e_d = {1'b0, m_q};
        end else begin
          s_d    = {1'b0, m_q};
          sval_d = rd_data_q;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          lnum_d      = LNUM_BITS'(s_q) + LNUM_BITS'(offset_q);
          col_d       = pos_q - sval_q;
          oovf_d      = ovf_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= np_new;
    if (rd_en) rd_data_q <= mem[m_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_pos_q  <= '0;
      bc_q        <= '0;
      last_cr_q   <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_pos_q  <= next_pos_d;
      bc_q        <= bc_d;
      last_cr_q   <= last_cr_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    s_q    <= s_d;
    e_q    <= e_d;
    m_q    <= m_d;
    sval_q <= sval_d;
    lnum_q <= lnum_d;
    col_q  <= col_d;
    oovf_q <= oovf_d;
  end

  assign out_valid_o   = out_valid_q;
  assign line_number_o = lnum_q;
  assign column_o      = col_q;
  assign overflow_o    = oovf_q;

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> ({1'b0, m_q} > s_q) && ({1'b0, m_q} < e_q))
    else $error("probe outside search window");

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && kind == KIND_QUERY |=> state_q == ST_SEARCH && s_q == '0)
    else $error("query did not start search");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("search result not loaded");

endmodule
